@@ hdl/dnsqp_pkg.sv @@
// Shared types and constants for the DNS query parser.
// Depends on nothing; every other file in hdl imports it.
package dnsqp_pkg;

    localparam int DEF_MAX_NAME_LEN = 256;

    localparam int HDR_BYTES  = 12;   // fixed DNS header length
    localparam int TAIL_BYTES = 4;    // type word + class word

    localparam logic [3:0] HDR_IDX_LAST  = 4'(HDR_BYTES - 1);
    localparam logic [3:0] TAIL_IDX_LAST = 4'(TAIL_BYTES - 1);
    localparam logic [3:0] IDX_ID_LO     = 4'd1;
    localparam logic [3:0] IDX_FLAGS_LO  = 4'd3;
    localparam logic [3:0] IDX_QD_LO     = 4'd5;
    localparam logic [3:0] IDX_AN_LO     = 4'd7;
    localparam logic [3:0] IDX_NS_LO     = 4'd9;
    localparam logic [3:0] IDX_TYPE_LO   = 4'd1;

    localparam logic [7:0] CHAR_DOT = 8'h2E;

    typedef logic [2:0] t_status;
    localparam t_status ST_CHAR   = 3'd0;
    localparam t_status ST_OK     = 3'd1;
    localparam t_status ST_SHORT  = 3'd2;
    localparam t_status ST_COUNTS = 3'd3;
    localparam t_status ST_LONG   = 3'd4;
    localparam t_status ST_TRUNC  = 3'd5;

    typedef struct packed {
        logic [7:0]  name_char;
        logic [15:0] query_id;
        logic        qr_bit;
        logic [3:0]  op_code;
        logic        aa_bit;
        logic        tc_bit;
        logic        rd_bit;
        logic        ra_bit;
        logic [3:0]  resp_code;
        logic [15:0] question_type;
        logic [15:0] question_class;
        t_status     status;
    } t_result;

    // Control from the parse logic to the output stage.
    typedef struct packed {
        logic    load;
        t_result result;
    } t_out_ctl;

endpackage

@@ hdl/dnsqp_if.sv @@
// Valid/ready channel interfaces for the DNS query parser.
// Depends on dnsqp_pkg for the result record type.
interface dnsqp_query_if ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface dnsqp_result_if import dnsqp_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result result;

    modport source (output valid, result, input ready);
    modport sink   (input valid, result, output ready);
endinterface

@@ hdl/dnsqp_out_stage.sv @@
// Result register of the DNS query parser: holds one result until transferred.
// Depends on dnsqp_pkg and dnsqp_if.
module dnsqp_out_stage import dnsqp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_out_ctl              i_ctl,
    output logic                  o_room,
    dnsqp_result_if.source        o_result
);

    logic    r_valid;
    t_result r_result;

    // Room when empty or when the held result leaves this cycle.
    assign o_room = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_ctl.load;
        end
        if (o_room && i_ctl.load) begin
            r_result <= i_ctl.result;
        end
    end

    assign o_result.valid  = r_valid;
    assign o_result.result = r_result;

endmodule

@@ hdl/dns_query_parser.sv @@
// DNS query parser: one datagram byte per transfer in, name characters and one
// summary per datagram out. Depends on dnsqp_pkg, dnsqp_if, dnsqp_out_stage.
//
// Feed a DNS query datagram one byte per transfer on i_query, with last_byte
// set on its final byte. The 12-byte header is parsed (id, flags, and the
// question/answer/authority counts, which must be 1/0/0; the additional count
// is ignored). The question name is decoded into dotted text: each name byte
// gives one result with status 0 and the character in name_char, and every
// label after the first is preceded by a dot result. The type and class words
// follow the name; anything after them is ignored. The final byte always
// produces one summary result carrying id, flag bits, type, class and a
// status: 1 ok, 2 short header, 3 bad counts, 4 name too long (the decoded
// name would reach MAX_NAME_LEN characters), 5 truncated. Fields whose bytes
// never arrived read 0. After the summary the parser is back in its reset
// state, ready for the next datagram. A byte that ends a datagram on a name
// character yields only the summary.
// Rate: one byte per clock, sustained. Each byte is parsed by a single level
// of logic from the parse state straight into the result register, so a
// result appears on o_result in the cycle after its byte's transfer. i_query is
// ready whenever the result register is empty or its content is taken in the
// same cycle; it drops only while a result waits on a stalled downstream.
module dns_query_parser import dnsqp_pkg::*; #(
    parameter int MAX_NAME_LEN = DEF_MAX_NAME_LEN
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dnsqp_query_if.sink   i_query,
    dnsqp_result_if.source o_result
);

    localparam int LEN_W = $clog2(MAX_NAME_LEN);
    localparam int SUM_W = $clog2(MAX_NAME_LEN + 256);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LABLEN,
        PH_LABEL,
        PH_TAIL,
        PH_DONE,
        PH_ERROR
    } t_phase_e;

    // Parse state
    t_phase_e    r_phase,       n_phase;
    logic [3:0]  r_idx,         n_idx;
    logic [15:0] r_words,       n_words;
    logic [15:0] r_id,          n_id;
    logic [15:0] r_flags,       n_flags;
    logic        r_counts_bad,  n_counts_bad;
    logic [7:0]  r_label_left,  n_label_left;
    logic [LEN_W-1:0] r_name_len, n_name_len;
    logic [15:0] r_type,        n_type;
    logic [15:0] r_class,       n_class;
    t_status     r_err,         n_err;

    logic        w_room;
    logic        w_accept;
    logic [7:0]  w_byte;
    logic [15:0] w_word;
    logic [SUM_W-1:0] w_pos;
    logic [SUM_W-1:0] w_label_end;
    logic [7:0]  w_left_dec;
    logic        w_have_char;
    logic [7:0]  w_char;
    t_status     w_status;
    t_out_ctl    w_ctl;

    assign i_query.ready = w_room;
    assign w_accept      = i_query.valid && w_room;
    assign w_byte        = i_query.data_byte;
    assign w_word        = {r_words[7:0], w_byte};

    // Start of the next label in the decoded text (after its dot, if any).
    assign w_pos       = SUM_W'(r_name_len) + SUM_W'(r_name_len != '0);
    assign w_label_end = w_pos + SUM_W'(w_byte);
    assign w_left_dec  = r_label_left - 8'd1;

    always_comb begin
        n_phase      = r_phase;
        n_idx        = r_idx;
        n_words      = r_words;
        n_id         = r_id;
        n_flags      = r_flags;
        n_counts_bad = r_counts_bad;
        n_label_left = r_label_left;
        n_name_len   = r_name_len;
        n_type       = r_type;
        n_class      = r_class;
        n_err        = r_err;
        w_have_char  = 1'b0;
        w_char       = 8'd0;

        case (r_phase)
            PH_HEADER: begin
                n_words = w_word;
                case (r_idx)
                    IDX_ID_LO:    n_id    = w_word;
                    IDX_FLAGS_LO: n_flags = w_word;
                    IDX_QD_LO:    if (w_word != 16'd1) n_counts_bad = 1'b1;
                    IDX_AN_LO:    if (w_word != 16'd0) n_counts_bad = 1'b1;
                    IDX_NS_LO:    if (w_word != 16'd0) n_counts_bad = 1'b1;
                    default: ;
                endcase
                if (r_idx >= HDR_IDX_LAST) begin
                    n_idx = 4'd0;
                    if (n_counts_bad) begin
                        n_phase = PH_ERROR;
                        n_err   = ST_COUNTS;
                    end else begin
                        n_phase = PH_LABLEN;
                    end
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            PH_LABLEN: begin
                if (w_byte == 8'd0) begin
                    n_phase = PH_TAIL;
                    n_idx   = 4'd0;
                end else if (w_label_end >= SUM_W'(MAX_NAME_LEN)) begin
                    n_phase = PH_ERROR;
                    n_err   = ST_LONG;
                end else begin
                    // dot between labels, none before the first
                    w_have_char  = (r_name_len != '0);
                    w_char       = CHAR_DOT;
                    n_name_len   = LEN_W'(w_pos);
                    n_label_left = w_byte;
                    n_phase      = PH_LABEL;
                end
            end
            PH_LABEL: begin
                w_have_char  = 1'b1;
                w_char       = w_byte;
                n_name_len   = r_name_len + LEN_W'(1);
                n_label_left = w_left_dec;
                if (w_left_dec == 8'd0) n_phase = PH_LABLEN;
            end
            PH_TAIL: begin
                n_words = w_word;
                if (r_idx == IDX_TYPE_LO) n_type = w_word;
                if (r_idx >= TAIL_IDX_LAST) begin
                    n_class = w_word;
                    n_phase = PH_DONE;
                    n_idx   = 4'd0;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            default: ;
        endcase
    end

    // Summary status from where the parse ends up after this byte.
    always_comb begin
        case (n_phase)
            PH_ERROR:  w_status = n_err;
            PH_HEADER: w_status = ST_SHORT;
            PH_DONE:   w_status = ST_OK;
            default:   w_status = ST_TRUNC;
        endcase
    end

    always_comb begin
        w_ctl.load = w_accept && (i_query.last_byte || w_have_char);
        w_ctl.result = '0;
        if (i_query.last_byte) begin
            w_ctl.result.query_id       = n_id;
            w_ctl.result.qr_bit         = n_flags[15];
            w_ctl.result.op_code        = n_flags[14:11];
            w_ctl.result.aa_bit         = n_flags[10];
            w_ctl.result.tc_bit         = n_flags[9];
            w_ctl.result.rd_bit         = n_flags[8];
            w_ctl.result.ra_bit         = n_flags[7];
            w_ctl.result.resp_code      = n_flags[3:0];
            w_ctl.result.question_type  = n_type;
            w_ctl.result.question_class = n_class;
            w_ctl.result.status         = w_status;
        end else begin
            w_ctl.result.name_char = w_char;
            w_ctl.result.status    = ST_CHAR;
        end
    end

    // State update; the final byte of a datagram returns to reset state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && i_query.last_byte)) begin
            r_phase      <= PH_HEADER;
            r_idx        <= 4'd0;
            r_words      <= 16'd0;
            r_id         <= 16'd0;
            r_flags      <= 16'd0;
            r_counts_bad <= 1'b0;
            r_label_left <= 8'd0;
            r_name_len   <= '0;
            r_type       <= 16'd0;
            r_class      <= 16'd0;
            r_err        <= ST_CHAR;
        end else if (w_accept) begin
            r_phase      <= n_phase;
            r_idx        <= n_idx;
            r_words      <= n_words;
            r_id         <= n_id;
            r_flags      <= n_flags;
            r_counts_bad <= n_counts_bad;
            r_label_left <= n_label_left;
            r_name_len   <= n_name_len;
            r_type       <= n_type;
            r_class      <= n_class;
            r_err        <= n_err;
        end
    end

    dnsqp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .o_room   (w_room),
        .o_result (o_result)
    );

endmodule

@@ tb/sv/dnsqp_tb_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard for the DNS query parser bench: byte-by-byte parse prediction and
// in-order result checking. Depends on dnsqp_pkg.
package dnsqp_tb_pkg;
    import dnsqp_pkg::*;

    typedef enum logic [2:0] {
        PP_HEADER, PP_LABLEN, PP_LABEL, PP_TAIL, PP_DONE, PP_ERROR
    } t_parse_phase;

    class dnsqp_scoreboard;
        int unsigned  max_name_len;
        t_result      pending_results[$];
        t_parse_phase phase;
        logic [3:0]   idx;
        logic [15:0]  word_acc;
        logic [15:0]  id_w, flags_w, type_w, class_w;
        bit           counts_bad;
        logic [7:0]   label_left;
        int unsigned  name_len;
        t_status      err_code;
        int unsigned  errors;
        int unsigned  chars_checked;
        int unsigned  status_hits[8];

        function new(int unsigned max_len);
            max_name_len  = max_len;
            errors        = 0;
            chars_checked = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            phase      = PP_HEADER;
            idx        = '0;
            word_acc   = '0;
            id_w       = '0;
            flags_w    = '0;
            type_w     = '0;
            class_w    = '0;
            counts_bad = 1'b0;
            label_left = '0;
            name_len   = 0;
            err_code   = ST_CHAR;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        // Advance the parse by one accepted byte and queue what it produces.
        function void note_byte(logic [7:0] b, logic last);
            t_result     r;
            bit          emit;
            logic [7:0]  ch;
            int unsigned pos;
            r    = '0;
            emit = 1'b0;
            ch   = '0;
            case (phase)
                PP_HEADER: begin
                    word_acc = {word_acc[7:0], b};
                    case (idx)
                        IDX_ID_LO:    id_w = word_acc;
                        IDX_FLAGS_LO: flags_w = word_acc;
                        IDX_QD_LO:    if (word_acc != 16'd1) counts_bad = 1'b1;
                        IDX_AN_LO,
                        IDX_NS_LO:    if (word_acc != 16'd0) counts_bad = 1'b1;
                        default: ;
                    endcase
                    if (idx >= HDR_IDX_LAST) begin
                        idx = '0;
                        if (counts_bad) begin
                            phase    = PP_ERROR;
                            err_code = ST_COUNTS;
                        end else begin
                            phase = PP_LABLEN;
                        end
                    end else begin
                        idx++;
                    end
                end
                PP_LABLEN: begin
                    if (b == 8'd0) begin
                        phase = PP_TAIL;
                        idx   = '0;
                    end else begin
                        pos = name_len + ((name_len != 0) ? 1 : 0);
                        if (pos + b >= max_name_len) begin
                            phase    = PP_ERROR;
                            err_code = ST_LONG;
                        end else begin
                            if (name_len != 0) begin
                                emit = 1'b1;
                                ch   = CHAR_DOT;
                            end
                            name_len   = pos;
                            label_left = b;
                            phase      = PP_LABEL;
                        end
                    end
                end
                PP_LABEL: begin
                    emit = 1'b1;
                    ch   = b;
                    name_len++;
                    label_left--;
                    if (label_left == 8'd0) phase = PP_LABLEN;
                end
                PP_TAIL: begin
                    word_acc = {word_acc[7:0], b};
                    if (idx == IDX_TYPE_LO) type_w = word_acc;
                    if (idx >= TAIL_IDX_LAST) begin
                        class_w = word_acc;
                        phase   = PP_DONE;
                        idx     = '0;
                    end else begin
                        idx++;
                    end
                end
                default: ;
            endcase

            if (!last) begin
                if (emit) begin
                    r.name_char = ch;
                    r.status    = ST_CHAR;
                    pending_results.push_back(r);
                end
                return;
            end

            // final byte: summary only, even if this byte was a name character
            r.query_id       = id_w;
            r.qr_bit         = flags_w[15];
            r.op_code        = flags_w[14:11];
            r.aa_bit         = flags_w[10];
            r.tc_bit         = flags_w[9];
            r.rd_bit         = flags_w[8];
            r.ra_bit         = flags_w[7];
            r.resp_code      = flags_w[3:0];
            r.question_type  = type_w;
            r.question_class = class_w;
            case (phase)
                PP_ERROR:  r.status = err_code;
                PP_HEADER: r.status = ST_SHORT;
                PP_DONE:   r.status = ST_OK;
                default:   r.status = ST_TRUNC;
            endcase
            pending_results.push_back(r);
            clear_parse();
        endfunction

        function void same_field(string fname, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, fname, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual 0x%h", $time, got);
                return;
            end
            want = pending_results.pop_front();
            if (want.status == ST_CHAR) chars_checked++;
            else status_hits[want.status]++;
            same_field("name_char",      want.name_char,      got.name_char);
            same_field("query_id",       want.query_id,       got.query_id);
            same_field("qr_bit",         want.qr_bit,         got.qr_bit);
            same_field("op_code",        want.op_code,        got.op_code);
            same_field("aa_bit",         want.aa_bit,         got.aa_bit);
            same_field("tc_bit",         want.tc_bit,         got.tc_bit);
            same_field("rd_bit",         want.rd_bit,         got.rd_bit);
            same_field("ra_bit",         want.ra_bit,         got.ra_bit);
            same_field("resp_code",      want.resp_code,      got.resp_code);
            same_field("question_type",  want.question_type,  got.question_type);
            same_field("question_class", want.question_class, got.question_class);
            same_field("status",         want.status,         got.status);
        endfunction
    endclass

endpackage

@@ tb/sv/dns_query_parser_tb.sv @@
`timescale 1ns / 1ps
// Top-level bench for dns_query_parser: drives datagram bytes, randomizes
// backpressure and checks results. Depends on dnsqp_pkg, dnsqp_if, dnsqp_tb_pkg.
module dns_query_parser_tb;
    import dnsqp_pkg::*;
    import dnsqp_tb_pkg::*;

    typedef logic [7:0] t_bytes[$];

    // Random part size in byte transfers, split over the four idling phases.
    // The directed set adds close to 900 bytes on top of this.
    localparam int RANDOM_BYTES = 440;
    // Cycles with no transfer on either side before the run is declared hung.
    localparam int QUIET_LIMIT  = 3000;
    // Result register is written in the cycle after its byte; spare cycles at the end.
    localparam int TAIL_CYCLES  = 8;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    dnsqp_query_if  query_ch ();
    dnsqp_result_if result_ch ();

    dns_query_parser dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_query  (query_ch),
        .o_result (result_ch)
    );

    dnsqp_scoreboard sb;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned bytes_sent;
    int unsigned datagrams_sent;
    int unsigned quiet_cycles;

    // Downstream backpressure: one fresh draw per cycle.
    always @(posedge i_clk) begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: values read here are the pre-edge ones, i.e. what the DUT saw.
    // Byte transfers feed the predictor before result transfers are checked.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (query_ch.valid && query_ch.ready)
                sb.note_byte(query_ch.data_byte, query_ch.last_byte);
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.result);
            if ((query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("dns_query_parser: mismatch");
                $finish;
            end
        end
    end

    // ---- datagram builders -------------------------------------------------

    function automatic void add_word(ref t_bytes d, input logic [15:0] w);
        d.push_back(w[15:8]);
        d.push_back(w[7:0]);
    endfunction

    function automatic void add_header(ref t_bytes d, input logic [15:0] id,
                                       input logic [15:0] flags, input logic [15:0] qd,
                                       input logic [15:0] an, input logic [15:0] ns,
                                       input logic [15:0] ar);
        add_word(d, id);
        add_word(d, flags);
        add_word(d, qd);
        add_word(d, an);
        add_word(d, ns);
        add_word(d, ar);
    endfunction

    // Length byte followed by random characters.
    function automatic void add_label(ref t_bytes d, input int len);
        d.push_back(8'(len));
        repeat (len) d.push_back(8'($urandom));
    endfunction

    function automatic void add_text(ref t_bytes d, input string s);
        d.push_back(8'(s.len()));
        for (int i = 0; i < s.len(); i++) d.push_back(s[i]);
    endfunction

    // Well-formed query with random content; zero labels gives the root name.
    function automatic void build_query(ref t_bytes d, input int nlabels);
        add_header(d, 16'($urandom), 16'($urandom), 16'd1, 16'd0, 16'd0, 16'($urandom));
        repeat (nlabels) add_label(d, $urandom_range(1, 12));
        d.push_back(8'h00);
        add_word(d, 16'($urandom));
        add_word(d, 16'($urandom));
    endfunction

    function automatic void trim_to(ref t_bytes d, input int len);
        while (d.size() > len) void'(d.pop_back());
    endfunction

    // ---- drivers -----------------------------------------------------------

    // One byte transfer. Valid only drops for a random idle gap, so
    // back-to-back bytes keep it high with a single assignment per edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            query_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        query_ch.valid     <= 1'b1;
        query_ch.data_byte <= b;
        query_ch.last_byte <= last;
        do @(posedge i_clk); while (!query_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_datagram(input t_bytes d);
        for (int i = 0; i < d.size(); i++) send_byte(d[i], i == d.size() - 1);
        datagrams_sent++;
    endtask

    // Hold the sender off until every predicted result has been taken.
    task automatic drain();
        query_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic directed_set();
        t_bytes d;
        logic [15:0] bad_qd [5] = '{16'd0, 16'd2, 16'h0101, 16'd1, 16'd1};
        logic [15:0] bad_an [5] = '{16'd0, 16'd0, 16'd0, 16'h8000, 16'd0};
        logic [15:0] bad_ns [5] = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd1};
        int          cuts [7]   = '{14, 15, 16, 18, 19, 20, 21};

        // header cut after one byte
        d.delete();
        d.push_back(8'hFF);
        send_datagram(d);

        // header cut mid-way with a bad question count already seen: still short
        d.delete();
        add_header(d, 16'h1234, 16'h0100, 16'd2, 16'd0, 16'd0, 16'd0);
        trim_to(d, 8);
        send_datagram(d);

        // complete header, nothing after it: truncated
        d.delete();
        add_header(d, 16'hBEEF, 16'h0120, 16'd1, 16'd0, 16'd0, 16'd0);
        send_datagram(d);

        // bad counts ending right on the last header byte
        d.delete();
        add_header(d, 16'h0F0F, 16'h8180, 16'd1, 16'd1, 16'd0, 16'd0);
        send_datagram(d);

        // each kind of bad count, followed by a full question that is ignored
        for (int k = 0; k < 5; k++) begin
            d.delete();
            add_header(d, 16'($urandom), 16'($urandom), bad_qd[k], bad_an[k], bad_ns[k],
                       16'd0);
            add_text(d, "x");
            d.push_back(8'h00);
            add_word(d, 16'd1);
            add_word(d, 16'd1);
            send_datagram(d);
        end

        // typical query, all header bits set, nonzero additional count
        d.delete();
        add_header(d, 16'hFFFF, 16'hFFFF, 16'd1, 16'd0, 16'd0, 16'hFFFF);
        add_text(d, "www");
        add_text(d, "example");
        add_text(d, "com");
        d.push_back(8'h00);
        add_word(d, 16'h0001);
        add_word(d, 16'h0001);
        send_datagram(d);

        // all-zero header words, root name, all-ones type and class
        d.delete();
        add_header(d, 16'h0000, 16'h0000, 16'd1, 16'd0, 16'd0, 16'd0);
        d.push_back(8'h00);
        add_word(d, 16'hFFFF);
        add_word(d, 16'hFFFF);
        send_datagram(d);

        // trailing bytes after the class word are ignored
        d.delete();
        add_header(d, 16'h5A5A, 16'h0100, 16'd1, 16'd0, 16'd0, 16'd1);
        add_text(d, "a");
        d.push_back(8'h00);
        add_word(d, 16'h001C);
        add_word(d, 16'h00FF);
        d.push_back(8'hFF);
        d.push_back(8'h00);
        d.push_back(8'hA5);
        send_datagram(d);

        // "ab.c": end mid-label, on a label's last char, on a length byte,
        // on the terminator, and after one, two and three tail bytes
        foreach (cuts[k]) begin
            d.delete();
            add_header(d, 16'h4321, 16'h0100, 16'd1, 16'd0, 16'd0, 16'd0);
            add_text(d, "ab");
            add_text(d, "c");
            d.push_back(8'h00);
            add_word(d, 16'h0010);
            add_word(d, 16'h0003);
            trim_to(d, cuts[k]);
            send_datagram(d);
        end

        // length byte with the top two bits set, then a label hitting the limit
        d.delete();
        add_header(d, 16'h7777, 16'h0000, 16'd1, 16'd0, 16'd0, 16'd0);
        add_label(d, 192);
        add_label(d, 63);
        d.push_back(8'h00);
        add_word(d, 16'd1);
        add_word(d, 16'd1);
        send_datagram(d);

        // same shape, one short of the limit: decoded name is exactly 255
        d.delete();
        add_header(d, 16'h8888, 16'h0000, 16'd1, 16'd0, 16'd0, 16'd0);
        add_label(d, 192);
        add_label(d, 62);
        d.push_back(8'h00);
        add_word(d, 16'h0005);
        add_word(d, 16'h0001);
        send_datagram(d);

        // length byte of all ones after a short label: too long at once
        d.delete();
        add_header(d, 16'h9999, 16'h0000, 16'd1, 16'd0, 16'd0, 16'd0);
        add_text(d, "z");
        d.push_back(8'hFF);
        d.push_back(8'h41);
        d.push_back(8'h42);
        send_datagram(d);
    endtask

    // Mostly well-formed queries, some broken or cut short, some pure noise.
    task automatic random_traffic(input int unsigned budget);
        t_bytes      d;
        int unsigned start;
        int          pick;
        int          which;
        logic [15:0] w;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            d.delete();
            pick = $urandom_range(99);
            if (pick < 88) begin
                build_query(d, $urandom_range(0, 4));
                if (pick < 55) begin
                    repeat ($urandom_range(0, 2)) d.push_back(8'($urandom));
                end else if (pick < 75) begin
                    trim_to(d, $urandom_range(1, d.size() - 1));
                end else begin
                    // corrupt one of the three checked count words
                    which = $urandom_range(0, 2);
                    w = 16'($urandom);
                    if (which == 0 && w == 16'd1) w = 16'd2;
                    if (which != 0 && w == 16'd0) w = 16'h0100;
                    d[4 + 2 * which] = w[15:8];
                    d[5 + 2 * which] = w[7:0];
                end
            end else if (pick < 96) begin
                repeat ($urandom_range(1, 30)) d.push_back(8'($urandom));
            end else begin
                repeat ($urandom_range(1, 11)) d.push_back(8'($urandom));
            end
            send_datagram(d);
        end
    endtask

    // ---- sequence ----------------------------------------------------------

    initial begin
        sb = new(DEF_MAX_NAME_LEN);
        i_rst_n            = 1'b0;
        query_ch.valid     = 1'b0;
        query_ch.data_byte = '0;
        query_ch.last_byte = 1'b0;
        result_ch.ready    = 1'b0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        bytes_sent         = 0;
        datagrams_sent     = 0;
        quiet_cycles       = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_set();
        drain();

        // idling phases: none, sender gaps, receiver stalls, light on both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            random_traffic(RANDOM_BYTES / 4);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d datagrams over %0d byte transfers, %0d name characters checked.",
                 datagrams_sent, bytes_sent, sb.chars_checked);
        $display("Summaries: ok %0d, short header %0d, bad counts %0d, too long %0d,",
                 sb.status_hits[ST_OK], sb.status_hits[ST_SHORT], sb.status_hits[ST_COUNTS],
                 sb.status_hits[ST_LONG]);
        $display("           truncated %0d.", sb.status_hits[ST_TRUNC]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("dns_query_parser: match");
        end else begin
            $display("dns_query_parser: mismatch");
        end
        $finish;
    end

endmodule
